// ===== rtl/core/nksel_pkg.sv =====
`default_nettype none

package nksel_pkg;

  localparam int COORD_W   = 20;
  localparam int VIEW_W    = 16;
  localparam int SLOT_W    = 10;
  localparam int SEC_W     = 4;
  localparam int DIST_W    = 44;
  localparam int CFG_IDX_W = 4;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int CENTRE_W  = 16;

  localparam logic [VIEW_W-1:0] VIEW_DIST_RST = 16'd1024;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_DRAIN = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_X     = 4'd0,
    CFG_CAM_Y     = 4'd1,
    CFG_CAM_Z     = 4'd2,
    CFG_VIEW_DIST = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [SLOT_W-1:0]         slot_tag;
    logic signed [COORD_W-1:0] chunk_x;
    logic signed [COORD_W-1:0] chunk_z;
    logic [SEC_W-1:0]          section_index;
    logic                      eligible;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] out_slot;
    logic [SEC_W-1:0]  out_section;
    logic [DIST_W-1:0] distance;
    logic              empty_res;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   value;
  } cfg_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SEC_W-1:0]  section;
    logic [DIST_W-1:0] dsq;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/nksel_chan_if.sv =====
`default_nettype none

interface nksel_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/nksel_dist.sv =====
`default_nettype none

module nksel_dist
  import nksel_pkg::*;
#(
  parameter int SECTION_HEIGHT = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [SEC_W-1:0]          section,
  input  wire logic signed [COORD_W-1:0] chunk_x,
  input  wire logic signed [COORD_W-1:0] chunk_z,
  input  wire logic signed [COORD_W-1:0] cam_x,
  input  wire logic signed [COORD_W-1:0] cam_y,
  input  wire logic signed [COORD_W-1:0] cam_z,
  input  wire logic [VIEW_W-1:0]         view_dist,
  output logic                           done,
  output logic                           pass,
  output logic [DIST_W-1:0]              dsq
);

  localparam int STAGES = 5;

  logic [STAGES-1:0]        vld_r;
  logic [STAGES-1:0]        vld_nxt;
  logic [CENTRE_W-1:0]      centre;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [DIFF_W-1:0]        ax_r, ay_r, az_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r, sqy4_r;
  logic [2*VIEW_W-1:0]      vdsq_r, vdsq4_r;
  logic [SQ_W:0]            hd_r;
  logic                     pass_r;
  logic [DIST_W-1:0]        dist_r;

  // section centre height, scaled to 4 fraction bits
  assign centre = (CENTRE_W'(section) * CENTRE_W'(SECTION_HEIGHT)
                   + CENTRE_W'(SECTION_HEIGHT / 2)) << 4;

  assign vld_nxt = {vld_r[STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= $signed({chunk_x[COORD_W-1], chunk_x}) - $signed({cam_x[COORD_W-1], cam_x});
    dz_r <= $signed({chunk_z[COORD_W-1], chunk_z}) - $signed({cam_z[COORD_W-1], cam_z});
    dy_r <= $signed({{(DIFF_W-CENTRE_W){1'b0}}, centre}) - $signed({cam_y[COORD_W-1], cam_y});

    ax_r <= dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    ay_r <= dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    az_r <= dz_r[DIFF_W-1] ? DIFF_W'(-dz_r) : DIFF_W'(dz_r);

    sqx_r  <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sqy_r  <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sqz_r  <= SQ_W'(az_r) * SQ_W'(az_r);
    vdsq_r <= (2*VIEW_W)'(view_dist) * (2*VIEW_W)'(view_dist);

    hd_r    <= (SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqz_r);
    sqy4_r  <= sqy_r;
    vdsq4_r <= vdsq_r;

    pass_r <= hd_r <= (SQ_W+1)'(vdsq4_r);
    dist_r <= DIST_W'(hd_r) + {sqy4_r[DIST_W-3:0], 2'b00};
  end

  assign done = vld_r[STAGES-1];
  assign pass = pass_r;
  assign dsq  = dist_r;

endmodule

`default_nettype wire

// ===== rtl/core/nksel_cell.sv =====
`default_nettype none

module nksel_cell
  import nksel_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,
  input  wire logic      tail,
  input  wire entry_t    new_ent,
  input  wire entry_t    left_ent,
  input  wire logic      left_gt,
  input  wire entry_t    right_ent,
  input  wire entry_t    head_ent,
  output entry_t         ent,
  output logic           gt
);

  entry_t ent_r;
  entry_t ent_nxt;

  // empty cells sort after everything
  assign gt = !occ || (ent_r.dsq > new_ent.dsq);

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.insert && gt) begin
      ent_nxt = left_gt ? left_ent : new_ent;
    end else if (ctl.shift) begin
      ent_nxt = tail ? head_ent : right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ===== rtl/core/nearest_k_section_selector.sv =====
`default_nettype none

// Keeps up to CANDIDATES sections sorted nearest first in a row of cells, one
// entry per cell. Mode 0 clears the list. Mode 1 offers a section: a five stage
// distance pipeline (differences, magnitudes, squares, horizontal sum, range
// check and weighting) feeds an insertion step in which every cell compares
// against the new distance and shifts right where it is farther; no new item is
// taken until the offer is through. Offers that fail the eligibility, section or
// slot checks are dropped without starting the pipeline. Mode 2 drains the list
// from the head cell while the row rotates, one entry per cycle into the output
// register while the sink keeps up, and leaves the list as it was; an empty
// list gives one beat with empty_res and last set. Mode 3 does nothing. The
// input is taken only between items; the final result may still wait in the
// output register while the next item is accepted. Configuration writes are
// taken every cycle and are meant for idle periods.
module nearest_k_section_selector
  import nksel_pkg::*;
#(
  parameter int CANDIDATES     = 48,
  parameter int SECTIONS       = 16,
  parameter int SECTION_HEIGHT = 16,
  parameter int SLOTS          = 1024
) (
  input wire logic   clk,
  input wire logic   rst_n,
  nksel_chan_if.sink   in_ch,
  nksel_chan_if.source out_ch,
  nksel_chan_if.sink   cfg_ch
);

  localparam int CW = $clog2(CANDIDATES + 1);

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_beat_t                 out_data_r, out_data_nxt;
  logic signed [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [VIEW_W-1:0]         view_r;
  logic [SLOT_W-1:0]         pend_slot_r;
  logic [SEC_W-1:0]          pend_sec_r;
  cell_ctl_t                 ctl;
  in_beat_t                  in_beat;
  logic                      in_acc;
  logic                      start;
  logic                      dist_done;
  logic                      dist_pass;
  logic [DIST_W-1:0]         dist_w;
  entry_t                    new_ent;
  entry_t                    ent [CANDIDATES];
  logic                      gt_w [CANDIDATES];

  assign in_beat     = in_ch.data;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign start       = in_acc && (mode_t'(in_beat.mode) == MODE_OFFER) && in_beat.eligible
                       && ((SEC_W+1)'(in_beat.section_index) < (SEC_W+1)'(SECTIONS))
                       && ((SLOT_W+1)'(in_beat.slot_tag) < (SLOT_W+1)'(SLOTS));

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      view_r  <= VIEW_DIST_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.data.index))
        CFG_CAM_X:     cam_x_r <= cfg_ch.data.value;
        CFG_CAM_Y:     cam_y_r <= cfg_ch.data.value;
        CFG_CAM_Z:     cam_z_r <= cfg_ch.data.value;
        CFG_VIEW_DIST: view_r  <= cfg_ch.data.value[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pend_slot_r <= in_beat.slot_tag;
      pend_sec_r  <= in_beat.section_index;
    end
  end

  nksel_dist #(
    .SECTION_HEIGHT(SECTION_HEIGHT)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .section   (in_beat.section_index),
    .chunk_x   (in_beat.chunk_x),
    .chunk_z   (in_beat.chunk_z),
    .cam_x     (cam_x_r),
    .cam_y     (cam_y_r),
    .cam_z     (cam_z_r),
    .view_dist (view_r),
    .done      (dist_done),
    .pass      (dist_pass),
    .dsq       (dist_w)
  );

  assign new_ent = '{slot: pend_slot_r, section: pend_sec_r, dsq: dist_w};

  // sorted row of cells, head at index 0
  for (genvar i = 0; i < CANDIDATES; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_ent = ent[i-1];
      assign left_gt  = gt_w[i-1];
    end

    if (i == CANDIDATES - 1) begin : g_end
      assign right_ent = ent[0];
    end else begin : g_body
      assign right_ent = ent[i+1];
    end

    nksel_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (cnt_r > CW'(i)),
      .tail      (cnt_r == CW'(i + 1)),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_gt   (left_gt),
      .right_ent (right_ent),
      .head_ent  (ent[0]),
      .ent       (ent[i]),
      .gt        (gt_w[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(in_beat.mode))
            MODE_CLEAR: cnt_nxt = '0;
            MODE_OFFER: begin
              if (start) begin
                state_nxt = ST_DIST;
              end
            end
            MODE_DRAIN: begin
              state_nxt = ST_DRAIN;
              idx_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          state_nxt = ST_IDLE;
          if (dist_pass) begin
            ctl.insert = 1'b1;
            if (cnt_r != CW'(CANDIDATES)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_data_nxt = '{out_slot: '0, out_section: '0, distance: '0,
                             empty_res: 1'b1, last: 1'b1};
            state_nxt    = ST_IDLE;
          end else begin
            ctl.shift    = 1'b1;
            out_data_nxt = '{out_slot: ent[0].slot, out_section: ent[0].section,
                             distance: ent[0].dsq, empty_res: 1'b0,
                             last: (idx_r + 1'b1 == cnt_r)};
            idx_nxt      = idx_r + 1'b1;
            if (idx_r + 1'b1 == cnt_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CANDIDATES))
    else $error("entry count above capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.empty_res |-> out_data_r.last)
    else $error("empty drain beat without last");

  a_done_in_dist: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> state_r == ST_DIST)
    else $error("distance result outside offer");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> cnt_r >= $past(cnt_r) && cnt_r != '0)
    else $error("insert shrank the list");
`endif

endmodule

`default_nettype wire
